[rtl/core/hogh_pkg.sv]
`default_nettype none

package hogh_pkg;

   // parameter defaults
   localparam int MAX_BINS_DEF      = 20;
   localparam int MAX_CELL_SIDE_DEF = 16;

   // field and port widths
   localparam int MAG_W      = 16;
   localparam int ANG_W      = 16;
   localparam int IDX_W      = 5;
   localparam int VAL_W      = 32;
   localparam int MODE_W     = 3;
   localparam int SIDE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // divider and product widths
   localparam int STEPQ_W   = 13;
   localparam int PROD_W    = 29;
   localparam int DVD_W     = 16;
   localparam int DIV_CNT_W = 5;
   localparam int ANG_Q_W   = 5;

   localparam logic [ANG_W-1:0] ANGLE_MAX = 16'd46080;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BIN_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CELL_SIDE = 2'd1;

   localparam logic [MODE_W-1:0] BIN_MODE_RST  = 3'd0;
   localparam logic [SIDE_W-1:0] CELL_SIDE_RST = 5'd8;

   // bin count codes
   localparam logic [MODE_W-1:0] MODE_B9  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_B10 = 3'd1;
   localparam logic [MODE_W-1:0] MODE_B12 = 3'd2;
   localparam logic [MODE_W-1:0] MODE_B15 = 3'd3;
   localparam logic [MODE_W-1:0] MODE_B18 = 3'd4;
   localparam logic [MODE_W-1:0] MODE_B20 = 3'd5;

   function automatic logic [IDX_W-1:0] mode_bins(input logic [MODE_W-1:0] mode);
      logic [IDX_W-1:0] nb;
      case (mode)
         MODE_B9:  nb = 5'd9;
         MODE_B10: nb = 5'd10;
         MODE_B12: nb = 5'd12;
         MODE_B15: nb = 5'd15;
         MODE_B18: nb = 5'd18;
         MODE_B20: nb = 5'd20;
         default:  nb = 5'd9;
      endcase
      return nb;
   endfunction

   // bin width in degrees, Q8.8
   function automatic logic [STEPQ_W-1:0] mode_stepq(input logic [MODE_W-1:0] mode);
      logic [STEPQ_W-1:0] sq;
      case (mode)
         MODE_B9:  sq = 13'd5120;
         MODE_B10: sq = 13'd4608;
         MODE_B12: sq = 13'd3840;
         MODE_B15: sq = 13'd3072;
         MODE_B18: sq = 13'd2560;
         MODE_B20: sq = 13'd2304;
         default:  sq = 13'd5120;
      endcase
      return sq;
   endfunction

   typedef struct packed {
      logic accept;
      logic div_a_start;
      logic take_idx;
      logic mul;
      logic rd_pix;
      logic div_h_start;
      logic wr_lo;
      logic wr_hi;
      logic emit_rd;
      logic emit_ld;
      logic clear_all;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic cell_done;
      logic last_k;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

[rtl/core/hogh_div.sv]
`default_nettype none

// shared restoring divider, one quotient bit per cycle
module hogh_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [hogh_pkg::DIV_CNT_W-1:0]   steps,
   input  wire logic [hogh_pkg::STEPQ_W-1:0]     rem_init,
   input  wire logic [hogh_pkg::DVD_W-1:0]       dvd_init,
   input  wire logic [hogh_pkg::STEPQ_W-1:0]     divisor,
   output logic                                  done,
   output logic [hogh_pkg::DVD_W-1:0]            quot,
   output logic [hogh_pkg::STEPQ_W-1:0]          rem
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [hogh_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [hogh_pkg::STEPQ_W-1:0]       rem_ff, rem_in;
   logic [hogh_pkg::DVD_W-1:0]         dvd_ff, dvd_in;
   logic [hogh_pkg::STEPQ_W-1:0]       dsr_ff, dsr_in;
   logic [hogh_pkg::STEPQ_W:0]         shifted;
   logic [hogh_pkg::STEPQ_W:0]         diff;
   logic                               ge;

   assign shifted = {rem_ff, dvd_ff[hogh_pkg::DVD_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         dvd_in  = dvd_init;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[hogh_pkg::STEPQ_W-1:0] : shifted[hogh_pkg::STEPQ_W-1:0];
         dvd_in = {dvd_ff[hogh_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hogh_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

[rtl/core/hogh_dp.sv]
`default_nettype none

module hogh_dp #(
   parameter int MAX_BINS      = hogh_pkg::MAX_BINS_DEF,
   parameter int MAX_CELL_SIDE = hogh_pkg::MAX_CELL_SIDE_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hogh_pkg::dp_cmd_type               cmd,
   output hogh_pkg::dp_sts_type                    sts,
   input  wire logic [hogh_pkg::MAG_W-1:0]         req_magnitude,
   input  wire logic [hogh_pkg::ANG_W-1:0]         req_angle,
   input  wire logic                               csr_wr,
   input  wire logic [hogh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hogh_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic [hogh_pkg::IDX_W-1:0]              rsp_bin_index,
   output logic [hogh_pkg::VAL_W-1:0]              rsp_bin_value,
   output logic                                    rsp_last_bin
);

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam int CNT_W  = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE + 1);
   localparam logic [hogh_pkg::IDX_W-1:0]  MAX_BINS_V = hogh_pkg::IDX_W'(MAX_BINS);
   localparam logic [hogh_pkg::SIDE_W-1:0] MAX_SIDE_V = hogh_pkg::SIDE_W'(MAX_CELL_SIDE);

   // configuration
   logic [hogh_pkg::MODE_W-1:0]   bin_mode_ff, bin_mode_in;
   logic [hogh_pkg::SIDE_W-1:0]   cell_side_ff, cell_side_in;

   // per pixel
   logic [hogh_pkg::MAG_W-1:0]    mag_ff;
   logic [hogh_pkg::ANG_W-1:0]    ang_ff, ang_in;
   logic [hogh_pkg::IDX_W-1:0]    nb_ff, nb_in;
   logic [hogh_pkg::STEPQ_W-1:0]  stepq_ff, stepq_in;
   logic [CNT_W-1:0]              target_ff, target_in;
   logic [hogh_pkg::MODE_W-1:0]   mode_eff;
   logic [hogh_pkg::SIDE_W-1:0]   side_c;

   logic [ADDR_W-1:0]             idx_ff, nxt_ff;
   logic [hogh_pkg::STEPQ_W-1:0]  rem_ff;
   logic [hogh_pkg::IDX_W-1:0]    q_idx, idx5, nxt5, idx_p1;
   logic                          in_range;
   logic [hogh_pkg::PROD_W-1:0]   prod_ff, numer;

   // divider hookup
   logic                          div_start, div_done;
   logic [hogh_pkg::DIV_CNT_W-1:0] div_steps;
   logic [hogh_pkg::STEPQ_W-1:0]  div_rem_init, div_rem;
   logic [hogh_pkg::DVD_W-1:0]    div_dvd_init, div_quot;

   // bin store
   logic [hogh_pkg::VAL_W-1:0]    mem_ff [MAX_BINS];
   logic [MAX_BINS-1:0]           vld_ff, vld_in;
   logic [hogh_pkg::VAL_W-1:0]    rda_ff, rdb_ff, rda_val, rdb_val;
   logic                          rda_vld_ff, rdb_vld_ff;
   logic [ADDR_W-1:0]             rda_addr, wr_addr;
   logic                          rda_en, wr_en;
   logic [hogh_pkg::MAG_W-1:0]    hi, lo, addend;
   logic [hogh_pkg::VAL_W-1:0]    base, wr_data;
   logic [hogh_pkg::VAL_W:0]      sum;

   // cell and emission
   logic [CNT_W-1:0]              cnt_ff, cnt_in, cnt_p1;
   logic [ADDR_W-1:0]             k_ff, k_in;
   logic [hogh_pkg::IDX_W-1:0]    k5;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hogh_pkg::IDX_W-1:0]    rsp_idx_ff;
   logic [hogh_pkg::VAL_W-1:0]    rsp_val_ff;
   logic                          rsp_last_ff;

   // configuration writes
   always_comb begin
      bin_mode_in  = bin_mode_ff;
      cell_side_in = cell_side_ff;
      if (csr_wr) begin
         case (csr_index)
            hogh_pkg::REG_BIN_MODE:  bin_mode_in  = csr_wdata[hogh_pkg::MODE_W-1:0];
            hogh_pkg::REG_CELL_SIDE: cell_side_in = csr_wdata[hogh_pkg::SIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // settings captured with each pixel
   always_comb begin
      if (bin_mode_ff > hogh_pkg::MODE_B20 ||
          hogh_pkg::mode_bins(bin_mode_ff) > MAX_BINS_V) begin
         mode_eff = hogh_pkg::MODE_B9;
      end else begin
         mode_eff = bin_mode_ff;
      end
      if (cell_side_ff == '0) begin
         side_c = hogh_pkg::SIDE_W'(1);
      end else if (cell_side_ff > MAX_SIDE_V) begin
         side_c = MAX_SIDE_V;
      end else begin
         side_c = cell_side_ff;
      end
      nb_in     = hogh_pkg::mode_bins(mode_eff);
      stepq_in  = hogh_pkg::mode_stepq(mode_eff);
      target_in = CNT_W'(side_c) * CNT_W'(side_c);
      ang_in    = (req_angle > hogh_pkg::ANGLE_MAX) ? hogh_pkg::ANGLE_MAX : req_angle;
   end

   // divider operands: bin search first, then the upper share
   assign numer     = prod_ff + hogh_pkg::PROD_W'(stepq_ff >> 1);
   assign div_start = cmd.div_a_start | cmd.div_h_start;

   always_comb begin
      if (cmd.div_a_start) begin
         div_steps    = hogh_pkg::DIV_CNT_W'(hogh_pkg::ANG_Q_W);
         div_rem_init = hogh_pkg::STEPQ_W'(ang_ff[hogh_pkg::ANG_W-1:hogh_pkg::ANG_Q_W]);
         div_dvd_init = ang_ff << (hogh_pkg::ANG_W - hogh_pkg::ANG_Q_W);
      end else begin
         div_steps    = hogh_pkg::DIV_CNT_W'(hogh_pkg::DVD_W);
         div_rem_init = numer[hogh_pkg::PROD_W-1:hogh_pkg::DVD_W];
         div_dvd_init = numer[hogh_pkg::DVD_W-1:0];
      end
   end

   hogh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem_init),
      .dvd_init (div_dvd_init),
      .divisor  (stepq_ff),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // bin pair; the 180 degree case folds onto bin 0
   always_comb begin
      q_idx    = div_quot[hogh_pkg::ANG_Q_W-1:0];
      in_range = q_idx < nb_ff;
      idx5     = in_range ? q_idx : '0;
      idx_p1   = idx5 + 1'b1;
      nxt5     = (idx_p1 >= nb_ff) ? '0 : idx_p1;
   end

   // bin store access
   assign rda_en   = cmd.rd_pix | cmd.emit_rd;
   assign rda_addr = cmd.emit_rd ? k_ff : idx_ff;
   assign rda_val  = rda_vld_ff ? rda_ff : '0;
   assign rdb_val  = rdb_vld_ff ? rdb_ff : '0;

   assign hi      = div_quot;
   assign lo      = mag_ff - hi;
   assign wr_en   = cmd.wr_lo | cmd.wr_hi;
   assign wr_addr = cmd.wr_lo ? idx_ff : nxt_ff;
   assign addend  = cmd.wr_lo ? lo : hi;
   assign base    = cmd.wr_lo ? rda_val : rdb_val;
   assign sum     = {1'b0, base} + (hogh_pkg::VAL_W + 1)'(addend);
   assign wr_data = sum[hogh_pkg::VAL_W] ? '1 : sum[hogh_pkg::VAL_W-1:0];

   always_comb begin
      vld_in = vld_ff;
      if (cmd.clear_all) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rda_en) begin
         rda_ff     <= mem_ff[rda_addr];
         rda_vld_ff <= vld_ff[rda_addr];
      end
      if (cmd.rd_pix) begin
         rdb_ff     <= mem_ff[nxt_ff];
         rdb_vld_ff <= vld_ff[nxt_ff];
      end
   end

   // pixel count and emission
   assign cnt_p1 = cnt_ff + 1'b1;
   assign k5     = hogh_pkg::IDX_W'(k_ff);

   always_comb begin
      cnt_in = cnt_ff;
      k_in   = k_ff;
      if (cmd.wr_hi) begin
         cnt_in = (cnt_p1 >= target_ff) ? '0 : cnt_p1;
         k_in   = '0;
      end else if (cmd.emit_ld) begin
         k_in = k_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_mode_ff  <= hogh_pkg::BIN_MODE_RST;
         cell_side_ff <= hogh_pkg::CELL_SIDE_RST;
         vld_ff       <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bin_mode_ff  <= bin_mode_in;
         cell_side_ff <= cell_side_in;
         vld_ff       <= vld_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.accept) begin
         mag_ff    <= req_magnitude;
         ang_ff    <= ang_in;
         nb_ff     <= nb_in;
         stepq_ff  <= stepq_in;
         target_ff <= target_in;
      end
      if (cmd.take_idx) begin
         idx_ff <= idx5[ADDR_W-1:0];
         nxt_ff <= nxt5[ADDR_W-1:0];
         rem_ff <= in_range ? div_rem : '0;
      end
      if (cmd.mul) begin
         prod_ff <= hogh_pkg::PROD_W'(mag_ff) * hogh_pkg::PROD_W'(rem_ff);
      end
      if (cmd.emit_ld) begin
         rsp_idx_ff  <= k5;
         rsp_val_ff  <= rda_val;
         rsp_last_ff <= sts.last_k;
      end
   end

   always_comb begin
      sts.div_done  = div_done;
      sts.cell_done = cnt_p1 >= target_ff;
      sts.last_k    = k5 == (nb_ff - 1'b1);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_idx_ff;
   assign rsp_bin_value = rsp_val_ff;
   assign rsp_last_bin  = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/hogh_ctrl.sv]
`default_nettype none

module hogh_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire hogh_pkg::dp_sts_type   sts,
   output hogh_pkg::dp_cmd_type        cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_ASTART = 10'b00_0000_0010,
      S_AWAIT  = 10'b00_0000_0100,
      S_MUL    = 10'b00_0000_1000,
      S_HSTART = 10'b00_0001_0000,
      S_HWAIT  = 10'b00_0010_0000,
      S_WLO    = 10'b00_0100_0000,
      S_WHI    = 10'b00_1000_0000,
      S_ERD    = 10'b01_0000_0000,
      S_ELD    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_ASTART;
            end
         end
         S_ASTART: begin
            cmd.div_a_start = 1'b1;
            state_in        = S_AWAIT;
         end
         S_AWAIT: begin
            if (sts.div_done) begin
               cmd.take_idx = 1'b1;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul    = 1'b1;
            cmd.rd_pix = 1'b1;
            state_in   = S_HSTART;
         end
         S_HSTART: begin
            cmd.div_h_start = 1'b1;
            state_in        = S_HWAIT;
         end
         S_HWAIT: begin
            if (sts.div_done) begin
               state_in = S_WLO;
            end
         end
         S_WLO: begin
            cmd.wr_lo = 1'b1;
            state_in  = S_WHI;
         end
         S_WHI: begin
            cmd.wr_hi = 1'b1;
            state_in  = sts.cell_done ? S_ERD : S_IDLE;
         end
         S_ERD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_ELD;
         end
         S_ELD: begin
            if (sts.out_free) begin
               cmd.emit_ld = 1'b1;
               if (sts.last_k) begin
                  cmd.clear_all = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/hog_cell_histogram.sv]
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  req      | in        | req_valid / req_ready | req_magnitude, req_angle
//  rsp      | out       | rsp_valid / rsp_ready | rsp_bin_index, rsp_bin_value, rsp_last_bin
//  csr      | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
//  one pixel is worked on from acceptance to the next free req_ready, using the shared
//  divider twice: first for the bin search, then for the rounded upper share
//  a completed cell then streams its bins one at a time through one bin store read port,
//  each read and then loaded into the output register, slower when rsp_ready is held low
//  synchronous active high reset clears the histogram, the pixel count and the registers
//  the last bin of a cell sits in the output register while the next pixel is worked on
//  csr_ready is always high; the user writes registers only between pixels, unenforced by the block

`default_nettype none

module hog_cell_histogram #(
   parameter int MAX_BINS      = hogh_pkg::MAX_BINS_DEF,
   parameter int MAX_CELL_SIDE = hogh_pkg::MAX_CELL_SIDE_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel transactions
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [hogh_pkg::MAG_W-1:0]         req_magnitude,
   input  wire logic [hogh_pkg::ANG_W-1:0]         req_angle,
   // bin transactions
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [hogh_pkg::IDX_W-1:0]              rsp_bin_index,
   output logic [hogh_pkg::VAL_W-1:0]              rsp_bin_value,
   output logic                                    rsp_last_bin,
   // register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [hogh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hogh_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   hogh_pkg::dp_cmd_type cmd;
   hogh_pkg::dp_sts_type sts;

   // register port never stalls
   assign csr_ready = 1'b1;

   // sequencer: pixel steps, then bin emission and clear
   hogh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // divider, multiplier, bin store and output register
   hogh_dp #(
      .MAX_BINS      (MAX_BINS),
      .MAX_CELL_SIDE (MAX_CELL_SIDE)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_magnitude (req_magnitude),
      .req_angle     (req_angle),
      .csr_wr        (csr_valid & csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_value (rsp_bin_value),
      .rsp_last_bin  (rsp_last_bin)
   );

endmodule

`default_nettype wire

[rtl/core/hogh_chk.sv]
`default_nettype none

module hogh_chk (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [hogh_pkg::IDX_W-1:0]     rsp_bin_index,
   input wire logic [hogh_pkg::VAL_W-1:0]     rsp_bin_value,
   input wire logic                           rsp_last_bin
);

   // a stalled bin transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index) &&
      $stable(rsp_bin_value) && $stable(rsp_last_bin))
      else $error("bin transaction changed while stalled");

   // a cell has at least nine bins
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_bin_index >= hogh_pkg::IDX_W'(8))
      else $error("last bin flagged too early");

   // no pixel is taken in the middle of a bin burst
   a_no_pixel_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |-> !req_ready)
      else $error("pixel ready during bin emission");

   // one pixel at a time
   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after a pixel transaction");

   // nothing comes out in the first cycle after reset is released
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("bin transaction right after reset");

endmodule

bind hog_cell_histogram hogh_chk u_hogh_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_bin_index (rsp_bin_index),
   .rsp_bin_value (rsp_bin_value),
   .rsp_last_bin  (rsp_last_bin)
);

`default_nettype wire

[dv/tb_hog_cell_histogram.sv]
`timescale 1ns / 1ps

module tb_hog_cell_histogram;
   import hogh_pkg::*;

   localparam int NUM_BIN_MAX   = MAX_BINS_DEF;
   localparam int SIDE_MAX      = MAX_CELL_SIDE_DEF;
   localparam int RAND_PIXELS   = 110;
   // receiver back-pressure long enough to stall the pixel input
   localparam int HOLD_CYCLES   = 400;
   // margin long enough for a pixel to pass through the shared divider
   localparam int SETTLE_CYCLES = 80;
   // cycles without any accepted transaction before the run is abandoned
   localparam int STALL_LIMIT   = 3000;
   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic [MAG_W-1:0] magnitude;
      logic [ANG_W-1:0] angle;
   } pixel_type;

   typedef struct {
      logic [IDX_W-1:0] bin_index;
      logic [VAL_W-1:0] bin_value;
      logic             last_bin;
   } bin_type;

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [MAG_W-1:0] req_magnitude = '0;
   logic [ANG_W-1:0] req_angle = '0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic req_ready;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_bin_index;
   logic [VAL_W-1:0] rsp_bin_value;
   logic rsp_last_bin;
   logic csr_ready;

   // histogram mirror: bin sums, pixel count and register copies
   logic [VAL_W-1:0] bin_sum [NUM_BIN_MAX];
   logic [8:0] pix_count = '0;
   logic [MODE_W-1:0] cfg_bin_mode = BIN_MODE_RST;
   logic [SIDE_W-1:0] cfg_cell_side = CELL_SIDE_RST;

   pixel_type pixel_q [$];        // pixels waiting to be offered
   bin_type   bin_expect_q [$];   // bins the block still owes us

   int pushed_cnt = 0;
   int accepted_cnt = 0;
   int send_idle_pct = 33;
   int recv_idle_pct = 66;
   int hold_seq = 0;
   int hold_ack = 0;
   int hold_left = 0;
   int err_cnt = 0;
   int quiet_cycles = 0;

   hog_cell_histogram u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_magnitude (req_magnitude),
      .req_angle     (req_angle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bin_index (rsp_bin_index),
      .rsp_bin_value (rsp_bin_value),
      .rsp_last_bin  (rsp_last_bin),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   // number of bins over 180 degrees; unused codes fall back to 9
   function automatic int unsigned bin_count(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_B10: return 10;
         MODE_B12: return 12;
         MODE_B15: return 15;
         MODE_B18: return 18;
         MODE_B20: return 20;
         default:  return 9;
      endcase
   endfunction

   function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W-1:0] acc,
                                                input int unsigned add);
      logic [VAL_W:0] s;
      s = {1'b0, acc} + add;
      return s[VAL_W] ? '1 : s[VAL_W-1:0];
   endfunction

   // vote one pixel into the histogram, queue the bins when the cell is full
   task automatic accumulate_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang);
      int unsigned n_bin, stepq, a, lo_bin, hi_bin, rem, hi_share, lo_share, side, goal;
      bin_type rec;
      n_bin = bin_count(cfg_bin_mode);
      stepq = ANGLE_MAX / n_bin;   // bin width in Q8.8 degrees
      a = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
      lo_bin = a / stepq;
      rem = a % stepq;
      // exactly 180 degrees is the same as 0
      if (lo_bin >= n_bin) begin
         lo_bin = 0;
         rem = 0;
      end
      // top bin wraps around to bin 0
      hi_bin = (lo_bin + 1 >= n_bin) ? 0 : lo_bin + 1;
      // upper share rounded half up, lower bin keeps the rest
      hi_share = (mag * rem + stepq / 2) / stepq;
      lo_share = mag - hi_share;
      bin_sum[lo_bin] = sat_sum(bin_sum[lo_bin], lo_share);
      bin_sum[hi_bin] = sat_sum(bin_sum[hi_bin], hi_share);

      side = cfg_cell_side;
      if (side == 0) side = 1;
      if (side > SIDE_MAX) side = SIDE_MAX;
      goal = side * side;
      pix_count = pix_count + 1'b1;
      if (pix_count >= goal) begin
         for (int k = 0; k < n_bin; k++) begin
            rec.bin_index = IDX_W'(k);
            rec.bin_value = bin_sum[k];
            rec.last_bin  = (k == n_bin - 1);
            bin_expect_q.push_back(rec);
         end
         foreach (bin_sum[k]) bin_sum[k] = '0;
         pix_count = '0;
      end
   endtask

   // pixel driver and register mirror
   always @(posedge clock) begin : drive_pixels
      pixel_type nxt_pix;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_BIN_MODE:  cfg_bin_mode = csr_wdata[MODE_W-1:0];
               REG_CELL_SIDE: cfg_cell_side = csr_wdata[SIDE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            accumulate_pixel(req_magnitude, req_angle);
            accepted_cnt++;
         end
         // slot is free: offer the next pixel or idle
         if (!req_valid || req_ready) begin
            if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt_pix = pixel_q.pop_front();
               req_valid     <= 1'b1;
               req_magnitude <= nxt_pix.magnitude;
               req_angle     <= nxt_pix.angle;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // bin receiver and checker
   always @(posedge clock) begin : check_bins
      bin_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (bin_expect_q.size() == 0) begin
               $error("unexpected bin transaction: bin_index %0d bin_value %0d",
                      rsp_bin_index, rsp_bin_value);
               err_cnt++;
            end else begin
               want = bin_expect_q.pop_front();
               if (rsp_bin_index !== want.bin_index) begin
                  $error("bin_index: expected %0d, actual %0d", want.bin_index, rsp_bin_index);
                  err_cnt++;
               end
               if (rsp_bin_value !== want.bin_value) begin
                  $error("bin_value: expected %0d, actual %0d", want.bin_value, rsp_bin_value);
                  err_cnt++;
               end
               if (rsp_last_bin !== want.last_bin) begin
                  $error("last_bin: expected %0d, actual %0d", want.last_bin, rsp_last_bin);
                  err_cnt++;
               end
            end
         end
         // long hold-off on request, otherwise random stalls
         if (hold_ack != hold_seq) begin
            hold_ack = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_hog_cell_histogram NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic push_pixel(input logic [MAG_W-1:0] mag, input logic [ANG_W-1:0] ang);
      pixel_type p;
      p.magnitude = mag;
      p.angle = ang;
      pixel_q.push_back(p);
      pushed_cnt++;
   endtask

   // random pixel, biased toward extremes and bin edges
   task automatic push_rand_pixel(input int unsigned n_bin);
      logic [MAG_W-1:0] mag;
      logic [ANG_W-1:0] ang;
      int unsigned stepq;
      stepq = ANGLE_MAX / n_bin;
      case ($urandom_range(9))
         0:       mag = '0;
         1:       mag = '1;
         2:       mag = MAG_W'($urandom_range(15));
         default: mag = MAG_W'($urandom);
      endcase
      case ($urandom_range(9))
         0:       ang = ANGLE_MAX;
         1:       ang = ANG_W'($urandom_range(65535, ANGLE_MAX + 1));
         2:       ang = ANG_W'($urandom_range(n_bin) * stepq);
         3:       ang = ANG_W'($urandom_range(n_bin) * stepq - 1);
         default: ang = ANG_W'($urandom_range(ANGLE_MAX));
      endcase
      push_pixel(mag, ang);
   endtask

   // block idle: every pixel in, every bin out, datapath drained
   task automatic settle();
      while (accepted_cnt != pushed_cnt) @(posedge clock);
      while (bin_expect_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [MODE_W-1:0] plan_mode;
      int unsigned plan_side, side, goal, n, rand_sent;
      foreach (bin_sum[k]) bin_sum[k] = '0;
      rand_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 9 bins and an 8x8 cell, so these only accumulate
      push_pixel(16'd16, 16'd0);
      push_pixel('1, ANGLE_MAX);
      push_pixel(16'd100, '1);      // above 180 saturates
      settle();
      // upper data bits are dropped, side 1 closes the cell on the next pixel
      write_reg(REG_CELL_SIDE, 8'hE1);
      push_pixel('1, ANGLE_MAX - 1'b1);   // top bin shares into bin 0
      push_pixel(16'd1, 16'd2560);        // half a step rounds up
      push_pixel(16'd0, 16'd12345);
      push_pixel('1, 16'd5120);           // exactly on a bin edge
      push_pixel(16'hAAAA, 16'h5555);
      settle();

      // every bin count, unused codes included
      for (int m = MODE_B10; m <= 7; m++) begin
         write_reg(REG_BIN_MODE, {5'($urandom), 3'(m)});
         push_pixel(MAG_W'($urandom), ANGLE_MAX - 1'b1);
         settle();
      end

      // a write to the unmapped index changes nothing
      write_reg(REG_SPARE, 8'hFF);
      write_reg(REG_BIN_MODE, 8'(MODE_B20));
      write_reg(REG_CELL_SIDE, 8'd0);     // zero side acts as 1
      push_pixel('1, 16'd1);
      push_pixel(16'h8000, 16'h8000);
      settle();

      // settings changed in the middle of a cell
      write_reg(REG_CELL_SIDE, 8'd16);
      repeat (3) push_rand_pixel(20);
      settle();
      write_reg(REG_BIN_MODE, 8'(MODE_B12));
      repeat (2) push_rand_pixel(12);
      settle();
      write_reg(REG_CELL_SIDE, 8'd2);     // count already past 4, next pixel closes it
      push_rand_pixel(12);
      settle();

      // back-pressure: receiver holds off while pixels keep coming
      write_reg(REG_BIN_MODE, 8'(MODE_B20));
      write_reg(REG_CELL_SIDE, 8'd1);
      plan_mode = MODE_B20;
      plan_side = 1;
      hold_seq++;
      repeat (12) push_rand_pixel(20);
      rand_sent += 12;
      // sender waits for every bin before going on
      settle();

      // random cells, mostly small ones
      while (rand_sent < RAND_PIXELS) begin
         if (rand_sent >= 2 * RAND_PIXELS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (rand_sent >= RAND_PIXELS / 3) begin
            send_idle_pct = 66;
            recv_idle_pct = 33;
         end
         settle();
         if ($urandom_range(2) != 0) begin
            plan_mode = ($urandom_range(9) == 0) ? MODE_W'($urandom_range(7, 6))
                                                 : MODE_W'($urandom_range(MODE_B20));
            write_reg(REG_BIN_MODE, {5'($urandom), plan_mode});
         end
         if ($urandom_range(2) != 0) begin
            case ($urandom_range(9))
               0, 1, 2, 3: plan_side = 1;
               4, 5, 6:    plan_side = 2;
               7:          plan_side = 3;
               8:          plan_side = 0;
               default:    plan_side = 4;
            endcase
            write_reg(REG_CELL_SIDE, {3'($urandom), 5'(plan_side)});
         end
         side = (plan_side == 0) ? 1 : plan_side;
         goal = side * side;
         n = goal * $urandom_range(3, 1);
         // sometimes leave a partial cell behind
         if ($urandom_range(3) == 0) n += $urandom_range(goal - 1);
         repeat (n) push_rand_pixel(bin_count(plan_mode));
         rand_sent += n;
      end

      // side written above the limit acts as the largest cell, so these only accumulate
      settle();
      plan_mode = MODE_W'($urandom_range(MODE_B20));
      write_reg(REG_BIN_MODE, 8'(plan_mode));
      write_reg(REG_CELL_SIDE, 8'hFF);
      repeat (12) push_rand_pixel(bin_count(plan_mode));
      settle();
      // a 3x3 cell is already past its target, the next pixel closes it
      write_reg(REG_CELL_SIDE, 8'd3);
      push_rand_pixel(bin_count(plan_mode));

      settle();
      if (err_cnt == 0) begin
         $display("tb_hog_cell_histogram OK");
      end else begin
         $display("tb_hog_cell_histogram NOT OK");
      end
      $finish;
   end

endmodule
